[design/bmsw_pkg.sv]
// Package for the banked register file and mode switch block.
// Holds mode codes, action codes, status bits and the shared struct types.
// No dependencies.
`default_nettype none

package bmsw_pkg;

    // Processor mode numbers
    localparam logic [4:0] MODE_USR = 5'h10;
    localparam logic [4:0] MODE_FIQ = 5'h11;
    localparam logic [4:0] MODE_IRQ = 5'h12;
    localparam logic [4:0] MODE_SVC = 5'h13;
    localparam logic [4:0] MODE_ABT = 5'h17;
    localparam logic [4:0] MODE_UND = 5'h1B;
    localparam logic [4:0] MODE_SYS = 5'h1F;

    // Action codes
    localparam logic [2:0] ACT_READ       = 3'd0;
    localparam logic [2:0] ACT_WRITE_REG  = 3'd1;
    localparam logic [2:0] ACT_SWITCH     = 3'd2;
    localparam logic [2:0] ACT_IRQ        = 3'd3;
    localparam logic [2:0] ACT_UNDEF      = 3'd4;
    localparam logic [2:0] ACT_WRITE_CPSR = 3'd5;
    localparam logic [2:0] ACT_WRITE_SPSR = 3'd6;
    localparam logic [2:0] ACT_WAIT_IRQ   = 3'd7;

    // Configuration register indexes
    localparam logic [7:0] CFG_HIGH_VECTORS = 8'd0;
    localparam logic [7:0] CFG_IS_ARM9      = 8'd1;

    // Status bits and vector constants
    localparam int unsigned BIT_T = 5;
    localparam int unsigned BIT_I = 7;
    localparam logic [31:0] HIGH_BASE    = 32'hFFFF_0000;
    localparam logic [31:0] VEC_UNDEF    = 32'h0000_0004;
    localparam logic [31:0] VEC_IRQ      = 32'h0000_0018;
    localparam logic [31:0] PC_AHEAD     = 32'h0000_0008;
    localparam logic [31:0] LINK_OFFSET  = 32'h0000_0004;
    localparam logic [31:0] STATUS_RESET = 32'h0000_001F;

    typedef struct packed {
        logic [15:0][31:0] vis;      // visible R0..R15
        logic [1:0][31:0]  usr;      // user/system R13, R14
        logic [6:0][31:0]  fiq;      // FIQ R8..R14
        logic [7:0][31:0]  priv;     // R13, R14 pairs: SVC, ABT, UND, IRQ
        logic [4:0][31:0]  spsr;     // saved status: SVC, ABT, UND, IRQ, FIQ
        logic [31:0]       cpsr;
        logic [31:0]       spsr_cur;
        logic              wait_flag;
    } t_state;

    typedef struct packed {
        logic high_vectors;
        logic is_arm9;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
        logic [4:0]  new_mode;
        logic [31:0] instruction_address;
    } t_item;

    typedef struct packed {
        logic        waiting_for_irq;
        logic [31:0] fetch_address;
        logic        halted;
        logic        exception_taken;
        logic [31:0] saved_status_word;
        logic [31:0] status_word;
        logic [4:0]  old_mode;
        logic [31:0] read_data;
    } t_result;

endpackage

`default_nettype wire

[design/bmsw_step.sv]
// Next-state and result logic for one item of the banked register file.
// Depends on bmsw_pkg.
`default_nettype none

module bmsw_step (
    input  bmsw_pkg::t_state  i_state,
    input  bmsw_pkg::t_cfg    i_cfg,
    input  bmsw_pkg::t_item   i_item,
    output bmsw_pkg::t_state  o_state,
    output bmsw_pkg::t_result o_result
);
    import bmsw_pkg::*;

    // {valid, slot} of a privileged mode in the pair and saved-status banks
    function automatic logic [2:0] priv_slot(input logic [4:0] m);
        logic [2:0] r;
        unique case (m)
            MODE_SVC: r = 3'b100;
            MODE_ABT: r = 3'b101;
            MODE_UND: r = 3'b110;
            MODE_IRQ: r = 3'b111;
            default:  r = 3'b000;
        endcase
        return r;
    endfunction

    function automatic t_state switch_mode(input t_state s_in, input logic [4:0] target);
        t_state     s;
        logic [4:0] prev;
        logic [2:0] ps;
        logic [31:0] tmp;
        s    = s_in;
        prev = s.cpsr[4:0];
        // store the outgoing mode's registers
        if (prev == MODE_USR || prev == MODE_SYS) begin
            s.usr[0] = s.vis[13];
            s.usr[1] = s.vis[14];
        end else if (prev == MODE_FIQ) begin
            for (int i = 0; i < 5; i++) begin
                tmp          = s.vis[8 + i];
                s.vis[8 + i] = s.fiq[i];
                s.fiq[i]     = tmp;
            end
            s.fiq[5]  = s.vis[13];
            s.fiq[6]  = s.vis[14];
            s.spsr[4] = s.spsr_cur;
        end else begin
            ps = priv_slot(prev);
            if (ps[2]) begin
                s.priv[{ps[1:0], 1'b0}] = s.vis[13];
                s.priv[{ps[1:0], 1'b1}] = s.vis[14];
                s.spsr[{1'b0, ps[1:0]}] = s.spsr_cur;
            end
        end
        // load the incoming mode's registers
        if (target == MODE_USR || target == MODE_SYS) begin
            s.vis[13] = s.usr[0];
            s.vis[14] = s.usr[1];
        end else if (target == MODE_FIQ) begin
            for (int i = 0; i < 5; i++) begin
                tmp          = s.vis[8 + i];
                s.vis[8 + i] = s.fiq[i];
                s.fiq[i]     = tmp;
            end
            s.vis[13]  = s.fiq[5];
            s.vis[14]  = s.fiq[6];
            s.spsr_cur = s.spsr[4];
        end else begin
            ps = priv_slot(target);
            if (ps[2]) begin
                s.vis[13]  = s.priv[{ps[1:0], 1'b0}];
                s.vis[14]  = s.priv[{ps[1:0], 1'b1}];
                s.spsr_cur = s.spsr[{1'b0, ps[1:0]}];
            end
        end
        s.cpsr = {s.cpsr[31:5], target};
        return s;
    endfunction

    t_state      s;
    logic [31:0] base;
    logic [31:0] fetch;
    logic        taken;
    logic        halt;

    always_comb begin
        s     = i_state;
        base  = i_cfg.high_vectors ? HIGH_BASE : '0;
        fetch = '0;
        taken = 1'b0;
        halt  = 1'b0;
        case (i_item.action)
            ACT_WRITE_REG: s.vis[i_item.reg_index] = i_item.write_data;
            ACT_SWITCH:    s = switch_mode(i_state, i_item.new_mode);
            ACT_IRQ: begin
                if (!i_state.cpsr[BIT_I]) begin
                    s            = switch_mode(i_state, MODE_IRQ);
                    s.vis[14]    = i_item.instruction_address + LINK_OFFSET;
                    s.spsr_cur   = i_state.cpsr;
                    s.cpsr[BIT_T] = 1'b0;
                    s.cpsr[BIT_I] = 1'b1;
                    fetch        = base + VEC_IRQ;
                    s.wait_flag  = 1'b0;
                    s.vis[15]    = fetch + PC_AHEAD;
                    taken        = 1'b1;
                end
            end
            ACT_UNDEF: begin
                if (i_cfg.high_vectors ^ i_cfg.is_arm9) begin
                    s             = switch_mode(i_state, MODE_UND);
                    s.vis[14]     = s.vis[15] - LINK_OFFSET;
                    s.spsr_cur    = i_state.cpsr;
                    s.cpsr[BIT_T] = 1'b0;
                    s.cpsr[BIT_I] = i_state.cpsr[BIT_I];
                    fetch         = base + VEC_UNDEF;
                    s.vis[15]     = fetch;
                    taken         = 1'b1;
                end else begin
                    halt = 1'b1;
                end
            end
            ACT_WRITE_CPSR: s.cpsr      = i_item.write_data;
            ACT_WRITE_SPSR: s.spsr_cur  = i_item.write_data;
            ACT_WAIT_IRQ:   s.wait_flag = 1'b1;
            default: ;
        endcase
    end

    assign o_state = s;

    assign o_result.read_data         = s.vis[i_item.reg_index];
    assign o_result.old_mode          = i_state.cpsr[4:0];
    assign o_result.status_word       = s.cpsr;
    assign o_result.saved_status_word = s.spsr_cur;
    assign o_result.exception_taken   = taken;
    assign o_result.halted            = halt;
    assign o_result.fetch_address     = fetch;
    assign o_result.waiting_for_irq   = s.wait_flag;

endmodule

`default_nettype wire

[design/banked_register_mode_switch_core.sv]
// Top level of the banked register file with processor-mode switching.
// Depends on bmsw_pkg and bmsw_step.
`default_nettype none

// Banked register file for a 32-bit core: sixteen visible registers, R13/R14
// banked per mode, R8..R12 banked for FIQ and a saved status copy per
// privileged mode. Each item on the s_axis channel (action in tuser, operands
// in tdata) is applied to the register state in the cycle it is accepted, and
// its single result is registered in the output register or the skid stage.
// One item is taken every cycle while tready is high; the rate is set by the
// single combinational step from the state registers back into themselves. A
// skid stage behind the output register lets the block take one more item
// while a result waits on m_axis; it stops accepting only when both are full.
// The configuration port (index 0 high_vectors, index 1 is_arm9, data bit 0)
// is always ready; other indexes are ignored. Reset state: all banks zero,
// status and saved status 0x1F (system mode), wait flag clear.

module banked_register_mode_switch_core (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // configuration write channel
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [7:0]   i_cfg_index,
    input  wire  [31:0]  i_cfg_data,
    // item input
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata, low bit up: reg_index[3:0], write_data[35:4], new_mode[40:36],
    // instruction_address[72:41], zero fill[79:73]
    input  wire  [79:0]  s_axis_tdata,
    // tuser: action[2:0]
    input  wire  [2:0]   s_axis_tuser,
    // result output
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // tdata, low bit up: read_data[31:0], old_mode[36:32], status_word[68:37],
    // saved_status_word[100:69], exception_taken[101], halted[102],
    // fetch_address[134:103], waiting_for_irq[135]
    output logic [135:0] m_axis_tdata
);
    import bmsw_pkg::*;

    t_state  r_state, n_state;
    t_cfg    r_cfg;
    t_item   item;
    t_result step_result;
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    logic    in_acc, drain;

    // unpack the incoming item
    assign item.action              = s_axis_tuser;
    assign item.reg_index           = s_axis_tdata[3:0];
    assign item.write_data          = s_axis_tdata[35:4];
    assign item.new_mode            = s_axis_tdata[40:36];
    assign item.instruction_address = s_axis_tdata[72:41];

    bmsw_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (item),
        .o_state  (n_state),
        .o_result (step_result)
    );

    assign s_axis_tready = !r_skid_valid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign drain         = r_out_valid && m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_vectors <= 1'b1;
            r_cfg.is_arm9      <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HIGH_VECTORS: r_cfg.high_vectors <= i_cfg_data[0];
                CFG_IS_ARM9:      r_cfg.is_arm9      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // register state: advance on every accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.vis       <= '0;
            r_state.usr       <= '0;
            r_state.fiq       <= '0;
            r_state.priv      <= '0;
            r_state.spsr      <= '0;
            r_state.cpsr      <= STATUS_RESET;
            r_state.spsr_cur  <= STATUS_RESET;
            r_state.wait_flag <= 1'b0;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    // output register and skid stage: valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || drain) begin
            // output slot free: refill from skid first, else from the new item
            r_out_valid  <= r_skid_valid || in_acc;
            r_skid_valid <= 1'b0;
        end else if (in_acc) begin
            // result held downstream: park the new item in the skid stage
            r_skid_valid <= 1'b1;
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || drain) begin
            r_out <= r_skid_valid ? r_skid : step_result;
        end else if (in_acc) begin
            r_skid <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // the skid stage fills only behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds an item with an empty output register");

    // after an accepted item the output register always holds a result next cycle
    a_accept_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_valid)
        else $error("accepted item did not reach the output register");

    // a held result must not be overwritten while the receiver stalls
    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");

    // a fetch address appears only with an exception entry, never with a halt
    a_fetch_only_on_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.exception_taken || r_out.fetch_address == '0)
                         && !(r_out.exception_taken && r_out.halted)))
        else $error("fetch address or halt flag inconsistent with exception entry");

endmodule

`default_nettype wire

[tb/sv/banked_register_mode_switch_core_test.sv]
// Testbench for banked_register_mode_switch_core: a stimulus table and random items are
// checked against a behavioural model of the banked register file.
// Depends on bmsw_pkg and the block itself.
`timescale 1ns / 1ps

module banked_register_mode_switch_core_test;

    import bmsw_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int IDLE_PCT    = 6;
    localparam int HOLD_CYCLES = 40;
    localparam int PHASE_ITEMS = 110;

    // Expected results that need no model: state straight after reset, and the
    // undefined trap refused with both configuration bits at their reset value.
    // Fields from the top: wfi, fetch, halted, taken, saved status, status, old mode, read.
    localparam t_result AT_RESET =
        '{1'b0, 32'd0, 1'b0, 1'b0, STATUS_RESET, STATUS_RESET, MODE_SYS, 32'd0};
    localparam t_result REFUSED_AT_RESET =
        '{1'b0, 32'd0, 1'b1, 1'b0, STATUS_RESET, STATUS_RESET, MODE_SYS, 32'd0};

    localparam logic [4:0] KNOWN_MODES [7] =
        '{MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC, MODE_ABT, MODE_UND, MODE_SYS};

    typedef struct packed {
        logic       is_cfg;      // register write rather than an item
        logic [7:0] cfg_index;
        logic       cfg_value;
        t_item      item;
        logic       typed;       // want holds a hand-written expectation
        t_result    want;
    } t_row;

    logic           i_clk         = 1'b0;
    logic           i_rst_n       = 1'b0;
    logic           i_cfg_valid   = 1'b0;
    logic [7:0]     i_cfg_index   = '0;
    logic [31:0]    i_cfg_data    = '0;
    logic           s_axis_tvalid = 1'b0;
    logic [79:0]    s_axis_tdata  = '0;
    logic [2:0]     s_axis_tuser  = '0;
    logic           m_axis_tready = 1'b0;
    wire            o_cfg_ready;
    wire            s_axis_tready;
    wire            m_axis_tvalid;
    wire  [135:0]   m_axis_tdata;

    // Model state: visible registers, banks, status words and configuration
    logic [31:0] gpr [16];
    logic [31:0] usr_bank [2];
    logic [31:0] fiq_bank [7];
    logic [31:0] priv_bank [8];
    logic [31:0] spsr_bank [5];
    logic [31:0] cpsr;
    logic [31:0] spsr;
    logic        wfi;
    logic        cfg_hivec;
    logic        cfg_arm9;

    t_result     due_results [$];
    int          mismatches   = 0;
    logic        quiet        = 1'b0;   // no idling on either side
    logic        hold_off_req = 1'b0;

    banked_register_mode_switch_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ---------------------------------------------------------------- model

    function automatic int priv_slot_of(input logic [4:0] mode);
        case (mode)
            MODE_SVC: return 0;
            MODE_ABT: return 1;
            MODE_UND: return 2;
            MODE_IRQ: return 3;
            default:  return -1;
        endcase
    endfunction

    function automatic void exchange_fiq_low();
        logic [31:0] t;
        for (int i = 0; i < 5; i++) begin
            t            = gpr[8 + i];
            gpr[8 + i]   = fiq_bank[i];
            fiq_bank[i]  = t;
        end
    endfunction

    // Store the outgoing mode's registers, load the incoming mode's, set the mode bits
    function automatic void swap_banks(input logic [4:0] target);
        logic [4:0] prev;
        int         s;
        prev = cpsr[4:0];
        if (prev == MODE_USR || prev == MODE_SYS) begin
            usr_bank[0] = gpr[13];
            usr_bank[1] = gpr[14];
        end else if (prev == MODE_FIQ) begin
            exchange_fiq_low();
            fiq_bank[5]  = gpr[13];
            fiq_bank[6]  = gpr[14];
            spsr_bank[4] = spsr;
        end else begin
            s = priv_slot_of(prev);
            if (s >= 0) begin
                priv_bank[2 * s]     = gpr[13];
                priv_bank[2 * s + 1] = gpr[14];
                spsr_bank[s]         = spsr;
            end
        end
        if (target == MODE_USR || target == MODE_SYS) begin
            gpr[13] = usr_bank[0];
            gpr[14] = usr_bank[1];
        end else if (target == MODE_FIQ) begin
            exchange_fiq_low();
            gpr[13] = fiq_bank[5];
            gpr[14] = fiq_bank[6];
            spsr    = spsr_bank[4];
        end else begin
            s = priv_slot_of(target);
            if (s >= 0) begin
                gpr[13] = priv_bank[2 * s];
                gpr[14] = priv_bank[2 * s + 1];
                spsr    = spsr_bank[s];
            end
        end
        cpsr[4:0] = target;
    endfunction

    // Apply one item to the model state and return the result it produces
    function automatic t_result regfile_step(input t_item it);
        t_result     r;
        logic [31:0] base;
        logic [31:0] old;
        r        = '0;
        base     = cfg_hivec ? HIGH_BASE : 32'd0;
        r.old_mode = cpsr[4:0];
        case (it.action)
            ACT_READ: ;
            ACT_WRITE_REG: gpr[it.reg_index] = it.write_data;
            ACT_SWITCH: swap_banks(it.new_mode);
            ACT_IRQ: begin
                // masked when I is set: nothing moves
                if (!cpsr[BIT_I]) begin
                    old = cpsr;
                    swap_banks(MODE_IRQ);
                    gpr[14]          = it.instruction_address + LINK_OFFSET;
                    spsr             = old;
                    cpsr[BIT_T]      = 1'b0;
                    cpsr[BIT_I]      = 1'b1;
                    r.fetch_address  = base + VEC_IRQ;
                    wfi              = 1'b0;
                    gpr[15]          = r.fetch_address + PC_AHEAD;
                    r.exception_taken = 1'b1;
                end
            end
            ACT_UNDEF: begin
                if (cfg_hivec ^ cfg_arm9) begin
                    old = cpsr;
                    swap_banks(MODE_UND);
                    gpr[14]          = gpr[15] - LINK_OFFSET;
                    spsr             = old;
                    cpsr[BIT_T]      = 1'b0;
                    cpsr[BIT_I]      = old[BIT_I];
                    r.fetch_address  = base + VEC_UNDEF;
                    gpr[15]          = r.fetch_address;
                    r.exception_taken = 1'b1;
                end else begin
                    r.halted = 1'b1;
                end
            end
            ACT_WRITE_CPSR: cpsr = it.write_data;
            ACT_WRITE_SPSR: spsr = it.write_data;
            ACT_WAIT_IRQ:   wfi  = 1'b1;
            default: ;
        endcase
        r.read_data         = gpr[it.reg_index];
        r.status_word       = cpsr;
        r.saved_status_word = spsr;
        r.waiting_for_irq   = wfi;
        return r;
    endfunction

    // -------------------------------------------------------------- checking

    task automatic note_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic compare_result(input t_result got, input t_result want);
        check_field("read_data",         got.read_data,         want.read_data);
        check_field("old_mode",          32'(got.old_mode),     32'(want.old_mode));
        check_field("status_word",       got.status_word,       want.status_word);
        check_field("saved_status_word", got.saved_status_word, want.saved_status_word);
        check_field("exception_taken",   32'(got.exception_taken),
                    32'(want.exception_taken));
        check_field("halted",            32'(got.halted),       32'(want.halted));
        check_field("fetch_address",     got.fetch_address,     want.fetch_address);
        check_field("waiting_for_irq",   32'(got.waiting_for_irq),
                    32'(want.waiting_for_irq));
    endtask

    // Pop the oldest expectation for every result taken from the block
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_results.size() == 0)
                note_mismatch("result with nothing outstanding");
            else
                compare_result(t_result'(m_axis_tdata), due_results.pop_front());
        end
    end

    // -------------------------------------------------------------- receiver

    // Stall at random, and once hold off for a long stretch so the skid fills
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // --------------------------------------------------------------- sender

    // Called at a falling edge; returns at the falling edge after acceptance.
    // Leave tvalid high so back-to-back items need no second assignment.
    task automatic drive_item(input t_item it, input logic typed, input t_result want);
        t_result predicted;
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.action;
        s_axis_tdata  <= {7'd0, it.instruction_address, it.new_mode, it.write_data,
                          it.reg_index};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = regfile_step(it);
        due_results.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    // Write a register once the block has drained
    task automatic write_register(input logic [7:0] idx, input logic val);
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= {31'($urandom()), val};
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_HIGH_VECTORS)
            cfg_hivec = val;
        else if (idx == CFG_IS_ARM9)
            cfg_arm9 = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Mostly well-formed traffic: known modes, status writes that usually
    // unmask IRQ so that entries keep being taken, and a share of odd modes
    function automatic t_item random_item();
        t_item       it;
        int unsigned pick;
        pick                   = $urandom_range(99);
        it.reg_index           = ($urandom_range(9) < 4) ? 4'($urandom_range(15, 8))
                                                         : 4'($urandom_range(15));
        it.write_data          = random_word();
        it.instruction_address = random_word();
        it.new_mode            = ($urandom_range(99) < 15) ? 5'($urandom_range(31))
                                                           : KNOWN_MODES[$urandom_range(6)];
        if (pick < 18)      it.action = ACT_READ;
        else if (pick < 36) it.action = ACT_WRITE_REG;
        else if (pick < 56) it.action = ACT_SWITCH;
        else if (pick < 70) it.action = ACT_IRQ;
        else if (pick < 78) it.action = ACT_UNDEF;
        else if (pick < 88) it.action = ACT_WRITE_CPSR;
        else if (pick < 94) it.action = ACT_WRITE_SPSR;
        else                it.action = ACT_WAIT_IRQ;
        if (it.action == ACT_WRITE_CPSR && $urandom_range(3) != 0) begin
            it.write_data[4:0]   = KNOWN_MODES[$urandom_range(6)];
            it.write_data[BIT_I] = ($urandom_range(3) == 0);
        end
        return it;
    endfunction

    function automatic t_row op_row(input logic [2:0] act, input logic [3:0] idx,
                                    input logic [31:0] data, input logic [4:0] mode,
                                    input logic [31:0] iaddr);
        t_row r;
        r                          = '0;
        r.item.action              = act;
        r.item.reg_index           = idx;
        r.item.write_data          = data;
        r.item.new_mode            = mode;
        r.item.instruction_address = iaddr;
        return r;
    endfunction

    function automatic t_row cfg_row(input logic [7:0] idx, input logic val);
        t_row r;
        r           = '0;
        r.is_cfg    = 1'b1;
        r.cfg_index = idx;
        r.cfg_value = val;
        return r;
    endfunction

    function automatic t_row pinned(input t_row r, input t_result w);
        t_row p;
        p       = r;
        p.typed = 1'b1;
        p.want  = w;
        return p;
    endfunction

    // ------------------------------------------------------------- stimulus

    initial begin
        t_row  directed [$];
        t_item it;
        logic  hv;
        logic  a9;

        for (int i = 0; i < 16; i++) gpr[i] = '0;
        for (int i = 0; i < 2; i++)  usr_bank[i] = '0;
        for (int i = 0; i < 7; i++)  fiq_bank[i] = '0;
        for (int i = 0; i < 8; i++)  priv_bank[i] = '0;
        for (int i = 0; i < 5; i++)  spsr_bank[i] = '0;
        cpsr      = STATUS_RESET;
        spsr      = STATUS_RESET;
        wfi       = 1'b0;
        cfg_hivec = 1'b1;
        cfg_arm9  = 1'b1;

        directed = '{
            pinned(op_row(ACT_READ,       4'd0,  32'd0,         5'd0,     32'd0),
                   AT_RESET),
            // both configuration bits set after reset: the trap is refused
            pinned(op_row(ACT_UNDEF,      4'd0,  32'd0,         5'd0,     32'd0),
                   REFUSED_AT_RESET),
            op_row(ACT_WRITE_REG,  4'd15, 32'hFFFF_FFFF,  5'd0,     32'd0),
            op_row(ACT_WRITE_REG,  4'd13, 32'hFFFF_FFFF,  5'd0,     32'd0),
            op_row(ACT_WRITE_REG,  4'd14, 32'h1234_5678,  5'd0,     32'd0),
            op_row(ACT_WRITE_REG,  4'd8,  32'hDEAD_BEEF,  5'd0,     32'd0),
            op_row(ACT_SWITCH,     4'd8,  32'd0,          MODE_FIQ, 32'd0),
            op_row(ACT_WRITE_REG,  4'd8,  32'h0000_0001,  5'd0,     32'd0),
            op_row(ACT_WRITE_SPSR, 4'd8,  32'hFFFF_FFFF,  5'd0,     32'd0),
            op_row(ACT_SWITCH,     4'd8,  32'd0,          MODE_SVC, 32'd0),
            // into a mode with no bank, then out of it again
            op_row(ACT_SWITCH,     4'd13, 32'd0,          5'h00,    32'd0),
            op_row(ACT_SWITCH,     4'd13, 32'd0,          MODE_FIQ, 32'd0),
            op_row(ACT_SWITCH,     4'd14, 32'd0,          MODE_USR, 32'd0),
            // I set: the entry is masked
            op_row(ACT_WRITE_CPSR, 4'd14, 32'h0000_0090,  5'd0,     32'd0),
            op_row(ACT_IRQ,        4'd14, 32'd0,          5'd0,     32'hFFFF_FFFC),
            op_row(ACT_WRITE_CPSR, 4'd14, 32'h0000_0030,  5'd0,     32'd0),
            op_row(ACT_IRQ,        4'd14, 32'd0,          5'd0,     32'hFFFF_FFFF),
            op_row(ACT_WAIT_IRQ,   4'd15, 32'd0,          5'd0,     32'd0),
            op_row(ACT_IRQ,        4'd15, 32'd0,          5'd0,     32'h0000_1000),
            cfg_row(CFG_HIGH_VECTORS, 1'b0),
            op_row(ACT_UNDEF,      4'd14, 32'd0,          5'd0,     32'd0),
            op_row(ACT_SWITCH,     4'd13, 32'd0,          MODE_ABT, 32'd0),
            op_row(ACT_SWITCH,     4'd13, 32'd0,          MODE_SYS, 32'd0),
            cfg_row(CFG_IS_ARM9, 1'b0),
            op_row(ACT_UNDEF,      4'd15, 32'd0,          5'd0,     32'd0),
            cfg_row(CFG_HIGH_VECTORS, 1'b1),
            op_row(ACT_UNDEF,      4'd15, 32'd0,          5'd0,     32'd0),
            op_row(ACT_READ,       4'd15, 32'hFFFF_FFFF,  5'h1F,    32'hFFFF_FFFF)
        };

        // Hold reset, then release it at a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[k]) begin
            if (directed[k].is_cfg)
                write_register(directed[k].cfg_index, directed[k].cfg_value);
            else
                drive_item(directed[k].item, directed[k].typed, directed[k].want);
        end

        // Random phases, one per configuration setting plus a random one.
        // Hold the receiver off at the start of the second; no idling in the third.
        for (int ph = 0; ph < 5; ph++) begin
            hv = (ph < 4) ? ph[0] : 1'($urandom_range(1));
            a9 = (ph < 4) ? ph[1] : 1'($urandom_range(1));
            write_register(CFG_HIGH_VECTORS, hv);
            write_register(CFG_IS_ARM9, a9);
            quiet = (ph == 2);
            if (ph == 1)
                hold_off_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                it = random_item();
                drive_item(it, 1'b0, '0);
            end
        end
        quiet = 1'b0;
        s_axis_tvalid <= 1'b0;

        // Drain, then allow a few cycles for anything stray
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Give up long after the slowest correct run would have finished
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
design/bmsw_pkg.sv
design/bmsw_step.sv
design/banked_register_mode_switch_core.sv
tb/sv/banked_register_mode_switch_core_test.sv
